[rtl/ecs_pkg.sv]
// ----------------------------------------------------------------------------
// ecs_pkg
// Types and constants shared by the electron candidate selection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ecs_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_CUT_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_REGION_SELECT   = 3'd1;
    localparam logic [2:0] CFG_PT_THRESHOLD    = 3'd2;
    localparam logic [2:0] CFG_ETA_LIMIT       = 3'd3;
    localparam logic [2:0] CFG_VERTEX_VALID    = 3'd4;
    localparam logic [2:0] CFG_CONV_DIST_LIMIT = 3'd5;
    localparam logic [2:0] CFG_CONV_DCOT_LIMIT = 3'd6;

    // region select codes, the unused code behaves as accept all
    localparam logic [1:0] REG_ACCEPT_ALL    = 2'd0;
    localparam logic [1:0] REG_REJECT_ENDCAP = 2'd1;
    localparam logic [1:0] REG_REJECT_BARREL = 2'd2;

    // fixed cut values in 1e-4 units, sized to the magnitude width
    localparam logic [16:0] D0_LIMIT   = 17'd200;
    localparam logic [11:0] EB_SIGIETA = 12'd100;
    localparam logic [16:0] EB_DPHI    = 17'd600;
    localparam logic [16:0] EB_DETA    = 17'd40;
    localparam logic [15:0] EB_HOE     = 16'd400;
    localparam logic [11:0] EE_SIGIETA = 12'd300;
    localparam logic [16:0] EE_DPHI    = 17'd300;
    localparam logic [16:0] EE_DETA    = 17'd70;
    localparam logic [15:0] EE_HOE     = 16'd250;

    // reset values of the configuration registers
    localparam logic [4:0]  RST_CUT_ENABLE   = 5'd31;
    localparam logic [1:0]  RST_REGION_SEL   = REG_ACCEPT_ALL;
    localparam logic [15:0] RST_PT_THRESHOLD = 16'd320;
    localparam logic [14:0] RST_ETA_LIMIT    = 15'd10240;
    localparam logic        RST_VERTEX_VALID = 1'b1;
    localparam logic [14:0] RST_CONV_LIMIT   = 15'd200;

    // raw candidate as it arrives on the stream
    typedef struct packed {
        logic        [15:0] pt;
        logic signed [15:0] eta;
        logic signed [15:0] impact_d0;
        logic        [16:0] trk_hcal_iso;
        logic        [15:0] ecal_iso;
        logic        [11:0] sigma_ieta;
        logic signed [15:0] dphi_track;
        logic signed [15:0] deta_track;
        logic        [15:0] had_over_em;
        logic signed [15:0] conv_dist;
        logic signed [15:0] conv_dcot;
        logic        [1:0]  region_flags;
    } t_cand;

    // candidate after magnitudes and isolation sum
    typedef struct packed {
        logic [15:0] pt;
        logic [16:0] aeta;
        logic [16:0] ad0;
        logic [17:0] iso_sum;
        logic [11:0] sig;
        logic [16:0] adphi;
        logic [16:0] adeta;
        logic [15:0] hoe;
        logic [16:0] adist;
        logic [16:0] adcot;
        logic        barrel;
        logic        endcap;
    } t_prep;

    // cut settings seen by the compare stage
    typedef struct packed {
        logic [1:0]  region_select;
        logic [15:0] pt_threshold;
        logic [14:0] eta_limit;
        logic        vertex_valid;
        logic [14:0] conv_dist_limit;
        logic [14:0] conv_dcot_limit;
    } t_cut_cfg;

    // per-group failure flags before enables are applied
    typedef struct packed {
        logic region;
        logic conv;
        logic id;
        logic iso;
        logic impact;
        logic pt_eta;
    } t_fail;

    // magnitude of a 16-bit two's complement value, 0..32768
    function automatic logic [16:0] mag16(input logic [15:0] v);
        logic [16:0] r;
        if (v[15]) begin
            r = 17'h10000 - {1'b0, v};
        end else begin
            r = {1'b0, v};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/electron_candidate_selection.sv]
// ----------------------------------------------------------------------------
// electron_candidate_selection
// Cut-based electron candidate selection, one keep/reject decision per item.
// ----------------------------------------------------------------------------
// Takes one candidate per clock while the input is ready and returns one result
// per candidate in the same order. The path is three register stages (magnitudes
// and isolation sum, cut comparisons, enable masking into the output register);
// a result passes through them in that order and leaves the output register when
// the output side is ready. Throughput is one item per cycle unless the output
// stalls, and a stalled output backs up stage by stage without loss. Registers
// are written through the plain write port and should only be changed while
// no candidate is in flight.
`default_nettype none

module electron_candidate_selection
    import ecs_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write port
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data,
    // candidate stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // pt, eta, impact_d0, trk_hcal_iso, ecal_iso, sigma_ieta, dphi_track,
    // deta_track, had_over_em, conv_dist, conv_dcot, zero pad
    input  wire logic [175:0] i_s_tdata,
    // region_flags
    input  wire logic [1:0]   i_s_tuser,
    // result stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // keep, fail_mask, zero pad
    output logic [7:0]        o_m_tdata
);

    logic        r_cut_enable;
    logic [4:0]  r_cut_en;
    logic [1:0]  r_region_select;
    logic [15:0] r_pt_threshold;
    logic [14:0] r_eta_limit;
    logic        r_vertex_valid;
    logic [14:0] r_conv_dist_limit;
    logic [14:0] r_conv_dcot_limit;

    t_cand    cand;
    t_cut_cfg cut_cfg;
    t_prep    prep;
    t_fail    fail;
    logic     prep_valid;
    logic     prep_ready;
    logic     cut_valid;
    logic     cut_ready;

    logic       r_out_valid;
    logic [5:0] r_mask;
    logic [5:0] n_mask;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_en          <= RST_CUT_ENABLE;
            r_region_select   <= RST_REGION_SEL;
            r_pt_threshold    <= RST_PT_THRESHOLD;
            r_eta_limit       <= RST_ETA_LIMIT;
            r_vertex_valid    <= RST_VERTEX_VALID;
            r_conv_dist_limit <= RST_CONV_LIMIT;
            r_conv_dcot_limit <= RST_CONV_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CUT_ENABLE:      r_cut_en          <= i_cfg_data[4:0];
                CFG_REGION_SELECT:   r_region_select   <= i_cfg_data[1:0];
                CFG_PT_THRESHOLD:    r_pt_threshold    <= i_cfg_data;
                CFG_ETA_LIMIT:       r_eta_limit       <= i_cfg_data[14:0];
                CFG_VERTEX_VALID:    r_vertex_valid    <= i_cfg_data[0];
                CFG_CONV_DIST_LIMIT: r_conv_dist_limit <= i_cfg_data[14:0];
                CFG_CONV_DCOT_LIMIT: r_conv_dcot_limit <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // any cut group enabled, kept for the masking check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_enable <= 1'b1;
        end else begin
            r_cut_enable <= |r_cut_en;
        end
    end

    // unpack the candidate
    assign cand.pt           = i_s_tdata[15:0];
    assign cand.eta          = i_s_tdata[31:16];
    assign cand.impact_d0    = i_s_tdata[47:32];
    assign cand.trk_hcal_iso = i_s_tdata[64:48];
    assign cand.ecal_iso     = i_s_tdata[80:65];
    assign cand.sigma_ieta   = i_s_tdata[92:81];
    assign cand.dphi_track   = i_s_tdata[108:93];
    assign cand.deta_track   = i_s_tdata[124:109];
    assign cand.had_over_em  = i_s_tdata[140:125];
    assign cand.conv_dist    = i_s_tdata[156:141];
    assign cand.conv_dcot    = i_s_tdata[172:157];
    assign cand.region_flags = i_s_tuser;

    assign cut_cfg.region_select   = r_region_select;
    assign cut_cfg.pt_threshold    = r_pt_threshold;
    assign cut_cfg.eta_limit       = r_eta_limit;
    assign cut_cfg.vertex_valid    = r_vertex_valid;
    assign cut_cfg.conv_dist_limit = r_conv_dist_limit;
    assign cut_cfg.conv_dcot_limit = r_conv_dcot_limit;

    // stage one
    ecs_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_cand  (cand),
        .o_valid (prep_valid),
        .i_ready (prep_ready),
        .o_prep  (prep)
    );

    // stage two
    ecs_cut u_cut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cut_cfg),
        .i_valid (prep_valid),
        .o_ready (prep_ready),
        .i_prep  (prep),
        .o_valid (cut_valid),
        .i_ready (cut_ready),
        .o_fail  (fail)
    );

    // stage three: enables applied, region always applies
    assign cut_ready = !r_out_valid || i_m_tready;
    assign n_mask    = {fail.region, {fail.conv, fail.id, fail.iso, fail.impact,
                        fail.pt_eta} & r_cut_en};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cut_ready) begin
            r_out_valid <= cut_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cut_ready && cut_valid) begin
            r_mask <= n_mask;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_mask, (r_mask == 6'd0)};

    // keep agrees with an empty failure mask
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == (o_m_tdata[6:1] == 6'd0)))
        else $error("keep does not match fail mask");

    // disabled cut groups never flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[5:1] & ~r_cut_en) == 5'd0))
        else $error("disabled cut group flagged");

    // with all cuts off only a region rejection can flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_cut_enable && $stable(r_cut_en)) |-> (o_m_tdata[5:1] == 5'd0))
        else $error("flag raised with every cut disabled");

    // empty output register means the whole pipe accepts
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output is empty");

    // reset empties the output
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result present after reset");

endmodule

`default_nettype wire

[rtl/ecs_prep.sv]
// ----------------------------------------------------------------------------
// ecs_prep
// First pipeline stage: field magnitudes and isolation sum, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_prep
    import ecs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_cand i_cand,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_prep      o_prep
);

    logic  r_valid;
    t_prep r_prep;
    t_prep n_prep;

    // stage moves when empty or when the next stage takes its item
    assign o_ready = !r_valid || i_ready;

    // magnitudes and the summed isolation
    always_comb begin
        n_prep.pt      = i_cand.pt;
        n_prep.aeta    = mag16(i_cand.eta);
        n_prep.ad0     = mag16(i_cand.impact_d0);
        n_prep.iso_sum = {1'b0, i_cand.trk_hcal_iso} + {2'b00, i_cand.ecal_iso};
        n_prep.sig     = i_cand.sigma_ieta;
        n_prep.adphi   = mag16(i_cand.dphi_track);
        n_prep.adeta   = mag16(i_cand.deta_track);
        n_prep.hoe     = i_cand.had_over_em;
        n_prep.adist   = mag16(i_cand.conv_dist);
        n_prep.adcot   = mag16(i_cand.conv_dcot);
        n_prep.barrel  = i_cand.region_flags[0];
        n_prep.endcap  = i_cand.region_flags[1];
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prep <= n_prep;
        end
    end

    assign o_valid = r_valid;
    assign o_prep  = r_prep;

endmodule

`default_nettype wire

[rtl/ecs_cut.sv]
// ----------------------------------------------------------------------------
// ecs_cut
// Second pipeline stage: all cut comparisons, registered as failure flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_cut
    import ecs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cut_cfg i_cfg,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_prep    i_prep,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_fail         o_fail
);

    logic        r_valid;
    t_fail       r_fail;
    t_fail       n_fail;
    logic [21:0] iso_x10;
    logic        eb_pass;
    logic        ee_pass;

    assign o_ready = !r_valid || i_ready;

    // ten times the isolation sum as two shifted terms
    assign iso_x10 = {1'b0, i_prep.iso_sum, 3'b000} + {3'b000, i_prep.iso_sum, 1'b0};

    // barrel and endcap shower id
    assign eb_pass = (i_prep.sig < EB_SIGIETA) && (i_prep.adphi < EB_DPHI)
                  && (i_prep.adeta < EB_DETA) && (i_prep.hoe < EB_HOE);
    assign ee_pass = (i_prep.sig < EE_SIGIETA) && (i_prep.adphi < EE_DPHI)
                  && (i_prep.adeta < EE_DETA) && (i_prep.hoe < EE_HOE);

    // failure flags per cut group
    always_comb begin
        n_fail.pt_eta = !(i_prep.pt > i_cfg.pt_threshold)
                     || !(i_prep.aeta < {2'b00, i_cfg.eta_limit});
        n_fail.impact = !i_cfg.vertex_valid || !(i_prep.ad0 < D0_LIMIT);
        n_fail.iso    = !(iso_x10 < {6'd0, i_prep.pt});
        n_fail.id     = (i_prep.barrel && !eb_pass) || (i_prep.endcap && !ee_pass);
        n_fail.conv   = (i_prep.adist < {2'b00, i_cfg.conv_dist_limit})
                     && (i_prep.adcot < {2'b00, i_cfg.conv_dcot_limit});
        n_fail.region = ((i_cfg.region_select == REG_REJECT_ENDCAP) && i_prep.endcap)
                     || ((i_cfg.region_select == REG_REJECT_BARREL) && i_prep.barrel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_fail <= n_fail;
        end
    end

    assign o_valid = r_valid;
    assign o_fail  = r_fail;

endmodule

`default_nettype wire

[verif/selection_checker.sv]
// ----------------------------------------------------------------------------
// selection_checker
// Decision predictor and scoreboard for the electron candidate selection.
// ----------------------------------------------------------------------------
// Mirrors the cut registers from the write port, predicts the keep flag and
// fail mask of every candidate transfer, and compares each decision transfer
// against the oldest prediction still waiting. Failures, outstanding
// predictions and compared decisions are handed to the testbench top.
module selection_checker
    import ecs_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    // pt, eta, impact_d0, trk_hcal_iso, ecal_iso, sigma_ieta, dphi_track,
    // deta_track, had_over_em, conv_dist, conv_dcot, zero pad
    input  wire logic [175:0] i_s_tdata,
    // region_flags
    input  wire logic [1:0]   i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    // keep, fail_mask, zero pad
    input  wire logic [7:0]   i_m_tdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    // fixed cut values, 1e-4 units
    localparam int IMPACT_MAX  = 200;
    localparam int ISO_FACTOR  = 10;
    localparam int BARREL_SIG  = 100;
    localparam int BARREL_DPHI = 600;
    localparam int BARREL_DETA = 40;
    localparam int BARREL_HOE  = 400;
    localparam int ENDCAP_SIG  = 300;
    localparam int ENDCAP_DPHI = 300;
    localparam int ENDCAP_DETA = 70;
    localparam int ENDCAP_HOE  = 250;

    // cut enable bits and region flag bits
    localparam int EN_PT_ETA  = 0;
    localparam int EN_IMPACT  = 1;
    localparam int EN_ISO     = 2;
    localparam int EN_ID      = 3;
    localparam int EN_CONV    = 4;
    localparam int BARREL_BIT = 0;
    localparam int ENDCAP_BIT = 1;

    // keeps the log short when a whole run goes wrong
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        t_fail mask;
        logic  keep;
    } t_decision;

    // mirrored cut registers
    logic [4:0]  cut_en;
    logic [1:0]  region_sel;
    logic [15:0] pt_thr;
    logic [14:0] eta_lim;
    logic        vtx_ok;
    logic [14:0] dist_win;
    logic [14:0] dcot_win;

    t_decision expected_decisions[$];
    int        errors  = 0;
    int        checked = 0;

    function automatic int magnitude(input logic signed [15:0] v);
        int x;
        x = int'(v);
        return (x < 0) ? -x : x;
    endfunction

    // keep flag and fail mask of one candidate under the mirrored registers
    function automatic t_decision predict_selection(input logic [175:0] data,
                                                    input logic [1:0] flags);
        t_decision d;
        int        pt, aeta, ad0, iso, sig, adphi, adeta, hoe, adist, adcot;
        logic      barrel, endcap;
        pt     = int'(data[15:0]);
        aeta   = magnitude(data[31:16]);
        ad0    = magnitude(data[47:32]);
        iso    = int'(data[64:48]) + int'(data[80:65]);
        sig    = int'(data[92:81]);
        adphi  = magnitude(data[108:93]);
        adeta  = magnitude(data[124:109]);
        hoe    = int'(data[140:125]);
        adist  = magnitude(data[156:141]);
        adcot  = magnitude(data[172:157]);
        barrel = flags[BARREL_BIT];
        endcap = flags[ENDCAP_BIT];
        d = '0;
        if (cut_en[EN_PT_ETA] && (pt <= int'(pt_thr) || aeta >= int'(eta_lim))) begin
            d.mask.pt_eta = 1'b1;
        end
        // no vertex fails every candidate whatever its impact
        if (cut_en[EN_IMPACT] && (!vtx_ok || ad0 >= IMPACT_MAX)) begin
            d.mask.impact = 1'b1;
        end
        // zero pt can never pass, the sum is never below zero
        if (cut_en[EN_ISO] && !(ISO_FACTOR * iso < pt)) begin
            d.mask.iso = 1'b1;
        end
        // a candidate with both flags has to pass both sets
        if (cut_en[EN_ID]) begin
            if (barrel && !(sig < BARREL_SIG && adphi < BARREL_DPHI &&
                            adeta < BARREL_DETA && hoe < BARREL_HOE)) begin
                d.mask.id = 1'b1;
            end
            if (endcap && !(sig < ENDCAP_SIG && adphi < ENDCAP_DPHI &&
                            adeta < ENDCAP_DETA && hoe < ENDCAP_HOE)) begin
                d.mask.id = 1'b1;
            end
        end
        if (cut_en[EN_CONV] && adist < int'(dist_win) && adcot < int'(dcot_win)) begin
            d.mask.conv = 1'b1;
        end
        // region select applies regardless of the enables, the spare code accepts all
        if ((region_sel == REG_REJECT_ENDCAP && endcap) ||
            (region_sel == REG_REJECT_BARREL && barrel)) begin
            d.mask.region = 1'b1;
        end
        d.keep = (d.mask == '0);
        return d;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        errors++;
    endtask

    // register mirror, prediction on candidate transfers, compare on decision transfers
    always @(posedge i_clk) begin
        t_decision want;
        t_decision got;
        if (!i_rst_n) begin
            cut_en     = RST_CUT_ENABLE;
            region_sel = RST_REGION_SEL;
            pt_thr     = RST_PT_THRESHOLD;
            eta_lim    = RST_ETA_LIMIT;
            vtx_ok     = RST_VERTEX_VALID;
            dist_win   = RST_CONV_LIMIT;
            dcot_win   = RST_CONV_LIMIT;
            expected_decisions.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CUT_ENABLE:      cut_en     = i_cfg_data[4:0];
                    CFG_REGION_SELECT:   region_sel = i_cfg_data[1:0];
                    CFG_PT_THRESHOLD:    pt_thr     = i_cfg_data;
                    CFG_ETA_LIMIT:       eta_lim    = i_cfg_data[14:0];
                    CFG_VERTEX_VALID:    vtx_ok     = i_cfg_data[0];
                    CFG_CONV_DIST_LIMIT: dist_win   = i_cfg_data[14:0];
                    CFG_CONV_DCOT_LIMIT: dcot_win   = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_decisions.insert(expected_decisions.size(),
                                          predict_selection(i_s_tdata, i_s_tuser));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.keep = i_m_tdata[0];
                got.mask = i_m_tdata[6:1];
                if (expected_decisions.size() == 0) begin
                    report_mismatch($sformatf("decision keep=%b mask=%b with no candidate waiting",
                                              got.keep, got.mask));
                end else begin
                    want = expected_decisions.pop_front();
                    if (got.keep !== want.keep) begin
                        report_mismatch($sformatf("decision %0d keep: got %b, want %b",
                                                  checked, got.keep, want.keep));
                    end
                    if (got.mask !== want.mask) begin
                        report_mismatch($sformatf("decision %0d fail_mask: got %b, want %b",
                                                  checked, got.mask, want.mask));
                    end
                    checked++;
                end
            end
        end
        o_pending    <= expected_decisions.size();
        o_fail_count <= errors;
        o_checked    <= checked;
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the electron candidate selection block.
// ----------------------------------------------------------------------------
// Sends a directed set of boundary and extreme candidates, then random phases
// of candidates under changing cut registers, mostly built around the cut
// edges with some raw noise. Both stream sides stall at random; the checker
// beside the block predicts and compares every decision.
module testbench;
    import ecs_pkg::*;

    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         RANDOM_PHASES   = 7;
    localparam int         ITEMS_PER_PHASE = 100;
    localparam int         NOISE_PCT       = 30;
    localparam int         ISO_FACTOR      = 10;
    localparam int         DPHI_SPAN       = 31416;
    localparam logic [2:0] CFG_INDEX_UNUSED = 3'd7;
    localparam logic [1:0] FLAG_NONE       = 2'b00;
    localparam logic [1:0] FLAG_BARREL     = 2'b01;
    localparam logic [1:0] FLAG_ENDCAP     = 2'b10;
    localparam logic [1:0] FLAG_BOTH       = 2'b11;
    localparam logic [1:0] REG_SPARE       = 2'd3;

    typedef struct {
        logic [4:0]  cut_enable;
        logic [1:0]  region_select;
        logic [15:0] pt_threshold;
        logic [14:0] eta_limit;
        logic        vertex_valid;
        logic [14:0] conv_dist_limit;
        logic [14:0] conv_dcot_limit;
    } t_cut_settings;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [175:0] i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [7:0]   o_m_tdata;

    int            fail_count;
    int            pending;
    int            checked;
    int            cycle_count    = 0;
    int            tx_idle_pct    = 8;
    int            rx_idle_pct    = 87;
    int            items_sent     = 0;
    int            directed_items = 0;
    int            settings_used  = 0;
    t_cut_settings cur;

    electron_candidate_selection i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    selection_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run limit reached with %0d decisions outstanding", pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // value a little either side of a cut edge, kept within range
    function automatic int near_edge(input int limit, input int spread, input int ceiling);
        int v;
        v = limit - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0) v = 0;
        if (v > ceiling) v = ceiling;
        return v;
    endfunction

    // two's complement value of a magnitude with a random sign
    function automatic logic [15:0] with_sign(input int mag);
        if (mag >= 32768) return 16'h8000;
        return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
    endfunction

    function automatic int id_value(input int limit);
        if ($urandom_range(0, 9) < 2) return near_edge(limit, 1, 65535);
        return $urandom_range(0, limit - 1);
    endfunction

    function automatic int conv_value(input int limit);
        case ($urandom_range(0, 9))
            0, 1, 2:    return near_edge(limit, 1, 32768);
            3, 4, 5, 6: return $urandom_range(limit, 32768);
            default:    return $urandom_range(0, limit);
        endcase
    endfunction

    function automatic t_cand good_candidate(input logic [1:0] flags);
        t_cand c;
        c = '0;
        c.pt           = 16'd1000;
        c.sigma_ieta   = 12'd50;
        c.conv_dist    = 16'd1000;
        c.conv_dcot    = 16'd1000;
        c.region_flags = flags;
        return c;
    endfunction

    // candidate around the current cut edges, or raw noise
    function automatic t_cand random_candidate(input bit noise);
        t_cand c;
        int    total;
        bit    use_barrel;
        if (noise) begin
            c.pt           = 16'($urandom);
            c.eta          = 16'($urandom);
            c.impact_d0    = 16'($urandom);
            c.trk_hcal_iso = 17'($urandom);
            c.ecal_iso     = 16'($urandom);
            c.sigma_ieta   = 12'($urandom);
            c.dphi_track   = 16'($urandom_range(0, 2 * DPHI_SPAN) - DPHI_SPAN);
            c.deta_track   = 16'($urandom);
            c.had_over_em  = 16'($urandom);
            c.conv_dist    = 16'($urandom);
            c.conv_dcot    = 16'($urandom);
            c.region_flags = 2'($urandom);
            return c;
        end
        c.region_flags = 2'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            c.pt = 16'(near_edge(cur.pt_threshold, 2, 65535));
        end else begin
            c.pt = 16'($urandom_range(cur.pt_threshold, 65535));
        end
        if ($urandom_range(0, 3) == 0) begin
            c.eta = with_sign(near_edge(cur.eta_limit, 2, 32768));
        end else begin
            c.eta = with_sign($urandom_range(0, cur.eta_limit));
        end
        if ($urandom_range(0, 4) == 0) begin
            c.impact_d0 = with_sign(near_edge(int'(D0_LIMIT), 2, 32768));
        end else begin
            c.impact_d0 = with_sign($urandom_range(0, int'(D0_LIMIT) - 1));
        end
        // isolation sum split between the two inputs
        case ($urandom_range(0, 9))
            0:       total = 0;
            1, 2:    total = near_edge(c.pt / ISO_FACTOR, 1, 65535);
            default: total = $urandom_range(0, c.pt / ISO_FACTOR);
        endcase
        c.trk_hcal_iso = 17'($urandom_range(0, total));
        c.ecal_iso     = 16'(total - int'(c.trk_hcal_iso));
        // shower values aimed at one of the two ID sets
        use_barrel = c.region_flags[0] && (!c.region_flags[1] || $urandom_range(0, 1));
        if (use_barrel) begin
            c.sigma_ieta  = 12'(id_value(int'(EB_SIGIETA)));
            c.dphi_track  = with_sign(id_value(int'(EB_DPHI)));
            c.deta_track  = with_sign(id_value(int'(EB_DETA)));
            c.had_over_em = 16'(id_value(int'(EB_HOE)));
        end else begin
            c.sigma_ieta  = 12'(id_value(int'(EE_SIGIETA)));
            c.dphi_track  = with_sign(id_value(int'(EE_DPHI)));
            c.deta_track  = with_sign(id_value(int'(EE_DETA)));
            c.had_over_em = 16'(id_value(int'(EE_HOE)));
        end
        c.conv_dist = with_sign(conv_value(cur.conv_dist_limit));
        c.conv_dcot = with_sign(conv_value(cur.conv_dcot_limit));
        return c;
    endfunction

    task automatic set_idling(input int phase);
        if (phase < 3) begin
            tx_idle_pct = 8;
            rx_idle_pct = 87;
        end else if (phase < 6) begin
            tx_idle_pct = 87;
            rx_idle_pct = 8;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // one candidate transfer, with random sender gaps in front
    task automatic send_candidate(input t_cand c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'd0, c.conv_dcot, c.conv_dist, c.had_over_em, c.deta_track,
                       c.dphi_track, c.sigma_ieta, c.ecal_iso, c.trk_hcal_iso,
                       c.impact_d0, c.eta, c.pt};
        i_s_tuser  <= c.region_flags;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // stop sending and wait until every decision is back and the pipe is empty
    task automatic wait_quiet(input int extra);
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // all registers, with junk above each register narrower than the data word
    task automatic program_settings(input t_cut_settings s);
        write_reg(CFG_CUT_ENABLE, {11'($urandom), s.cut_enable});
        write_reg(CFG_REGION_SELECT, {14'($urandom), s.region_select});
        write_reg(CFG_PT_THRESHOLD, s.pt_threshold);
        write_reg(CFG_ETA_LIMIT, {1'($urandom), s.eta_limit});
        write_reg(CFG_VERTEX_VALID, {15'($urandom), s.vertex_valid});
        write_reg(CFG_CONV_DIST_LIMIT, {1'($urandom), s.conv_dist_limit});
        write_reg(CFG_CONV_DCOT_LIMIT, {1'($urandom), s.conv_dcot_limit});
        write_reg(CFG_INDEX_UNUSED, 16'($urandom));
        i_cfg_we <= 1'b0;
        cur = s;
        settings_used++;
    endtask

    // main sequence
    initial begin
        t_cut_settings s;
        t_cand         c;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset settings
        cur.cut_enable      = RST_CUT_ENABLE;
        cur.region_select   = RST_REGION_SEL;
        cur.pt_threshold    = RST_PT_THRESHOLD;
        cur.eta_limit       = RST_ETA_LIMIT;
        cur.vertex_valid    = RST_VERTEX_VALID;
        cur.conv_dist_limit = RST_CONV_LIMIT;
        cur.conv_dcot_limit = RST_CONV_LIMIT;
        settings_used = 1;
        set_idling(0);
        send_candidate(good_candidate(FLAG_BARREL));
        send_candidate(good_candidate(FLAG_ENDCAP));
        send_candidate(good_candidate(FLAG_BOTH));
        // no region flag, so shower values are never looked at
        c = good_candidate(FLAG_NONE);
        c.sigma_ieta  = 12'd4095;
        c.had_over_em = 16'hFFFF;
        send_candidate(c);
        // both flags, passes the endcap set but not the barrel one
        c = good_candidate(FLAG_BOTH);
        c.sigma_ieta = 12'd200;
        send_candidate(c);
        // every field at its top
        c = '{16'hFFFF, 16'h7FFF, 16'h7FFF, 17'h1FFFF, 16'hFFFF, 12'hFFF,
              16'(DPHI_SPAN), 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, FLAG_BOTH};
        send_candidate(c);
        // every field at its bottom, zero pt among them
        c = '{16'h0000, 16'h8000, 16'h8000, 17'h0, 16'h0, 12'h0,
              16'(-DPHI_SPAN), 16'h8000, 16'h0, 16'h8000, 16'h8000, FLAG_NONE};
        send_candidate(c);
        c = good_candidate(FLAG_BARREL);
        c.pt = RST_PT_THRESHOLD;
        send_candidate(c);
        c.pt = RST_PT_THRESHOLD + 16'd1;
        send_candidate(c);
        c = good_candidate(FLAG_BARREL);
        c.eta = 16'(int'(RST_ETA_LIMIT) - 1);
        send_candidate(c);
        c.eta = 16'(-int'(RST_ETA_LIMIT));
        send_candidate(c);
        c = good_candidate(FLAG_ENDCAP);
        c.impact_d0 = 16'(int'(D0_LIMIT) - 1);
        send_candidate(c);
        c.impact_d0 = 16'(-int'(D0_LIMIT));
        send_candidate(c);
        // isolation exactly at the edge, then just inside
        c = good_candidate(FLAG_BARREL);
        c.trk_hcal_iso = 17'd60;
        c.ecal_iso     = 16'd40;
        send_candidate(c);
        c.trk_hcal_iso = 17'd99;
        c.ecal_iso     = 16'd0;
        send_candidate(c);
        c = good_candidate(FLAG_BARREL);
        c.dphi_track = 16'(DPHI_SPAN);
        send_candidate(c);
        c = good_candidate(FLAG_ENDCAP);
        c.deta_track = 16'(-int'(EE_DETA));
        send_candidate(c);
        // conversion veto inside both windows, then outside one
        c = good_candidate(FLAG_BARREL);
        c.conv_dist = 16'd0;
        c.conv_dcot = 16'd0;
        send_candidate(c);
        c.conv_dist = 16'(-(int'(RST_CONV_LIMIT) - 1));
        c.conv_dcot = {1'b0, RST_CONV_LIMIT};
        send_candidate(c);
        // no vertex and the spare region select code
        wait_quiet(SETTLE_CYCLES);
        s = cur;
        s.vertex_valid  = 1'b0;
        s.region_select = REG_SPARE;
        program_settings(s);
        send_candidate(good_candidate(FLAG_BARREL));
        send_candidate(good_candidate(FLAG_ENDCAP));
        send_candidate(good_candidate(FLAG_BOTH));
        directed_items = items_sent;

        // random phases, extremes of the registers first
        for (int p = 1; p <= RANDOM_PHASES; p++) begin
            wait_quiet(SETTLE_CYCLES);
            case (p)
                1: s = '{5'd31, REG_REJECT_ENDCAP, 16'd0, 15'h7FFF, 1'b0,
                         15'h7FFF, 15'h7FFF};
                2: s = '{5'd0, REG_REJECT_BARREL, 16'hFFFF, 15'd0, 1'b1,
                         15'd0, 15'd0};
                3: s = '{5'd31, REG_SPARE, RST_PT_THRESHOLD, RST_ETA_LIMIT, 1'b1,
                         RST_CONV_LIMIT, RST_CONV_LIMIT};
                default: begin
                    s.cut_enable      = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd31;
                    s.region_select   = 2'($urandom);
                    s.pt_threshold    = 16'($urandom_range(0, 2000));
                    s.eta_limit       = 15'($urandom_range(2000, 20000));
                    s.vertex_valid    = ($urandom_range(0, 3) != 0);
                    s.conv_dist_limit = 15'($urandom_range(0, 2000));
                    s.conv_dcot_limit = 15'($urandom_range(0, 2000));
                end
            endcase
            program_settings(s);
            set_idling(p);
            repeat (ITEMS_PER_PHASE) begin
                send_candidate(random_candidate($urandom_range(0, 99) < NOISE_PCT));
            end
        end

        wait_quiet(DRAIN_CYCLES);
        $display("sent %0d candidates (%0d directed) under %0d register settings",
                 items_sent, directed_items, settings_used);
        $display("compared %0d decisions, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ecs_pkg.sv
rtl/ecs_prep.sv
rtl/ecs_cut.sv
rtl/electron_candidate_selection.sv
verif/selection_checker.sv
verif/testbench.sv
